[rtl/kdrq_pkg.sv]
// Shared types and constants of the keyed device request queue.
// Used by the queue cell, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package kdrq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned OpW           = 3;
  localparam int unsigned TagW          = 8;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned InDataW       = 48;
  localparam int unsigned OutDataW      = 48;

  // Input bit positions inside the slave tdata.
  localparam int unsigned InOpLsb  = 0;
  localparam int unsigned InTagLsb = InOpLsb + OpW;
  localparam int unsigned InKeyLsb = InTagLsb + TagW;

  typedef enum logic [OpW-1:0] {
    OpInsTail    = 3'd0,
    OpInsKey     = 3'd1,
    OpRemHead    = 3'd2,
    OpRemKey     = 3'd3,
    OpRemKeyBusy = 3'd4,
    OpRemTag     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    SelHead = 2'd0,
    SelKey  = 2'd1,
    SelTag  = 2'd2
  } rem_sel_e;

  // Broadcast to every cell: how each cell decides whether it is a hit.
  typedef struct packed {
    logic            ins_mode;
    logic            keyed;
    rem_sel_e        sel;
    logic [TagW-1:0] tag;
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

  // Broadcast to every cell: which update happens at this edge.
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/kdrq_cell.sv]
// One slot of the request queue: holds a tag, a key and an occupied bit.
// Shifts toward the tail on insert and toward the head on removal. Uses kdrq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdrq_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  kdrq_pkg::cell_ctrl_t   ctrl_i,
  input  wire  kdrq_pkg::cell_cmd_t    cmd_i,
  input  wire                          rem_by_key_i,
  input  wire                          prev_valid_i,
  input  wire  [kdrq_pkg::TagW-1:0]    prev_tag_i,
  input  wire  [kdrq_pkg::KeyW-1:0]    prev_key_i,
  input  wire                          next_valid_i,
  input  wire  [kdrq_pkg::TagW-1:0]    next_tag_i,
  input  wire  [kdrq_pkg::KeyW-1:0]    next_key_i,
  input  wire                          before_i,
  output logic                         before_o,
  output logic                         first_o,
  output logic                         tail_gt_o,
  output logic                         valid_o,
  output logic [kdrq_pkg::TagW-1:0]    tag_o,
  output logic [kdrq_pkg::KeyW-1:0]    key_o
);

  logic                      valid_q, valid_d;
  logic [kdrq_pkg::TagW-1:0] tag_q, tag_d;
  logic [kdrq_pkg::KeyW-1:0] key_q, key_d;
  logic                      hit;
  logic                      stored_gt;
  logic                      stored_lt;

  assign stored_gt = key_q > ctrl_i.key;
  assign stored_lt = key_q < ctrl_i.key;

  always_comb begin
    if (ctrl_i.ins_mode) begin
      // The first free slot always hits, so a plain insert lands at the tail.
      hit = !valid_q || (ctrl_i.keyed && stored_gt);
    end else begin
      case (ctrl_i.sel)
        kdrq_pkg::SelHead: hit = valid_q;
        kdrq_pkg::SelKey:  hit = valid_q && (!rem_by_key_i || !stored_lt);
        kdrq_pkg::SelTag:  hit = valid_q && (tag_q == ctrl_i.tag);
        default:           hit = 1'b0;
      endcase
    end
  end

  assign first_o   = hit && !before_i;
  assign before_o  = hit || before_i;
  assign tail_gt_o = valid_q && !next_valid_i && stored_gt;

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    key_d   = key_q;
    if (cmd_i.ins_en) begin
      if (before_i) begin
        valid_d = prev_valid_i;
        tag_d   = prev_tag_i;
        key_d   = prev_key_i;
      end else if (hit) begin
        valid_d = 1'b1;
        tag_d   = ctrl_i.tag;
        key_d   = ctrl_i.key;
      end
    end else if (cmd_i.rem_en && (hit || before_i)) begin
      valid_d = next_valid_i;
      tag_d   = next_tag_i;
      key_d   = next_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign key_o   = key_q;

endmodule

`default_nettype wire

[rtl/keyed_device_request_queue_unit.sv]
// The result of a transfer appears on the master side in the cycle after it is accepted.
// Throughput: one transfer per cycle unless the output stalls; every cell compares and
// shifts in the same cycle, so the critical path is the hit chain via all QUEUE_DEPTH cells.
// The slave side stays ready while the output register is empty or being drained.
// Reset clears the busy flag, every occupied bit and the result valid bit; no clearing pass.
// Top level of the keyed device request queue; uses kdrq_pkg and kdrq_cell.
`timescale 1ns / 1ps
`default_nettype none

module keyed_device_request_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = kdrq_pkg::DefQueueDepth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // From bit 0: op[3], tag[8], key[32], zero fill.
  input  wire  [kdrq_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // From bit 0: queued, got_entry, entry_tag[8], entry_key[32], busy_now, overflow, zero fill.
  output logic [kdrq_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  logic                      s_fire;
  kdrq_pkg::op_e             op;
  logic [kdrq_pkg::TagW-1:0] in_tag;
  logic [kdrq_pkg::KeyW-1:0] in_key;

  kdrq_pkg::cell_ctrl_t ctrl;
  kdrq_pkg::cell_cmd_t  cmd_raw, cmd;
  logic                 rem_by_key;

  logic [QUEUE_DEPTH:0]      before_chain;
  logic [QUEUE_DEPTH-1:0]    first_vec;
  logic [QUEUE_DEPTH-1:0]    tail_gt_vec;
  logic [QUEUE_DEPTH+1:0]    valid_vec;
  logic [kdrq_pkg::TagW-1:0] tag_arr [QUEUE_DEPTH+2];
  logic [kdrq_pkg::KeyW-1:0] key_arr [QUEUE_DEPTH+2];

  logic                      busy_q, busy_d;
  logic                      queued, got, ovf;
  logic [kdrq_pkg::TagW-1:0] sel_tag;
  logic [kdrq_pkg::KeyW-1:0] sel_key;
  logic                      empty, full, found;

  logic                      out_valid_q;
  logic                      out_queued_q, out_got_q, out_busy_q, out_ovf_q;
  logic [kdrq_pkg::TagW-1:0] out_tag_q;
  logic [kdrq_pkg::KeyW-1:0] out_key_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign op     = kdrq_pkg::op_e'(s_axis_tdata_i[kdrq_pkg::InOpLsb +: kdrq_pkg::OpW]);
  assign in_tag = s_axis_tdata_i[kdrq_pkg::InTagLsb +: kdrq_pkg::TagW];
  assign in_key = s_axis_tdata_i[kdrq_pkg::InKeyLsb +: kdrq_pkg::KeyW];

  // Index 0 and QUEUE_DEPTH+1 are the empty ends of the chain; cell i sits at index i+1.
  assign valid_vec[0]               = 1'b0;
  assign valid_vec[QUEUE_DEPTH+1]   = 1'b0;
  assign tag_arr[0]                 = '0;
  assign key_arr[0]                 = '0;
  assign tag_arr[QUEUE_DEPTH+1]     = '0;
  assign key_arr[QUEUE_DEPTH+1]     = '0;
  assign before_chain[0]            = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    kdrq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmd_i        (cmd),
      .rem_by_key_i (rem_by_key),
      .prev_valid_i (valid_vec[i]),
      .prev_tag_i   (tag_arr[i]),
      .prev_key_i   (key_arr[i]),
      .next_valid_i (valid_vec[i+2]),
      .next_tag_i   (tag_arr[i+2]),
      .next_key_i   (key_arr[i+2]),
      .before_i     (before_chain[i]),
      .before_o     (before_chain[i+1]),
      .first_o      (first_vec[i]),
      .tail_gt_o    (tail_gt_vec[i]),
      .valid_o      (valid_vec[i+1]),
      .tag_o        (tag_arr[i+1]),
      .key_o        (key_arr[i+1])
    );
  end

  assign empty      = !valid_vec[1];
  assign full       = valid_vec[QUEUE_DEPTH];
  assign found      = before_chain[QUEUE_DEPTH];
  assign rem_by_key = |tail_gt_vec;

  // The selected cell is one-hot, so an OR over the masked cells picks its entry.
  always_comb begin
    sel_tag = '0;
    sel_key = '0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      sel_tag = sel_tag | (first_vec[i] ? tag_arr[i+1] : '0);
      sel_key = sel_key | (first_vec[i] ? key_arr[i+1] : '0);
    end
  end

  always_comb begin
    ctrl.ins_mode  = 1'b0;
    ctrl.keyed     = 1'b0;
    ctrl.sel       = kdrq_pkg::SelHead;
    ctrl.tag       = in_tag;
    ctrl.key       = in_key;
    cmd_raw.ins_en = 1'b0;
    cmd_raw.rem_en = 1'b0;
    busy_d         = busy_q;
    queued         = 1'b0;
    got            = 1'b0;
    ovf            = 1'b0;
    unique case (op) inside
      kdrq_pkg::OpInsTail, kdrq_pkg::OpInsKey: begin
        ctrl.ins_mode = 1'b1;
        ctrl.keyed    = (op == kdrq_pkg::OpInsKey);
        if (!busy_q) begin
          busy_d = 1'b1;
        end else if (full) begin
          ovf = 1'b1;
        end else begin
          cmd_raw.ins_en = 1'b1;
          queued         = 1'b1;
        end
      end
      kdrq_pkg::OpRemHead, kdrq_pkg::OpRemKey, kdrq_pkg::OpRemKeyBusy: begin
        ctrl.sel = (op == kdrq_pkg::OpRemHead) ? kdrq_pkg::SelHead : kdrq_pkg::SelKey;
        if (empty || ((op == kdrq_pkg::OpRemKeyBusy) && !busy_q)) begin
          busy_d = 1'b0;
        end else begin
          cmd_raw.rem_en = 1'b1;
          got            = 1'b1;
        end
      end
      kdrq_pkg::OpRemTag: begin
        ctrl.sel = kdrq_pkg::SelTag;
        if (found) begin
          cmd_raw.rem_en = 1'b1;
          queued         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd.ins_en = cmd_raw.ins_en && s_fire;
  assign cmd.rem_en = cmd_raw.rem_en && s_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        busy_q <= busy_d;
      end
      out_valid_q <= s_fire || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_queued_q <= queued;
      out_got_q    <= got;
      out_tag_q    <= got ? sel_tag : '0;
      out_key_q    <= got ? sel_key : '0;
      out_busy_q   <= busy_d;
      out_ovf_q    <= ovf;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_ovf_q, out_busy_q, out_key_q, out_tag_q,
                            out_got_q, out_queued_q};

endmodule

`default_nettype wire

[rtl/kdrq_checker.sv]
// Port-level checks for keyed_device_request_queue_unit, bound to the top level.
// Uses kdrq_pkg for the bus widths.
`timescale 1ns / 1ps
`default_nettype none

module kdrq_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_tvalid_i,
  input wire                           s_tready_i,
  input wire                           m_tvalid_i,
  input wire                           m_tready_i,
  input wire [kdrq_pkg::OutDataW-1:0]  m_tdata_i
);

  // An overflow result never also reports a stored or returned entry.
  a_ovf_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && m_tdata_i[43]) |-> (!m_tdata_i[0] && !m_tdata_i[1]))
    else $error("overflow reported together with queued or got_entry");

  // Without a returned entry the entry fields read as zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tdata_i[1]) |-> (m_tdata_i[41:2] == 40'd0))
    else $error("entry fields not zero while got_entry is low");

  // A result shows up only after an accepted transfer or while an older one waits.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !$past(m_tvalid_i)) |-> $past(s_tvalid_i && s_tready_i))
    else $error("result appeared without an accepted transfer");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled result changed");

endmodule

bind keyed_device_request_queue_unit kdrq_checker u_kdrq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire
